[rtl/core/deadline_job_sequencer_macros.svh]
// Assertion macros for the deadline job sequencer
`ifndef DEADLINE_JOB_SEQUENCER_MACROS_SVH
`define DEADLINE_JOB_SEQUENCER_MACROS_SVH

// Clocked implication, held off during reset
`define DJS_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, held off during reset
`define DJS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

[rtl/core/djs_pkg.sv]
// ----------------------------------------------------------------------------
// djs_pkg
// Shared types for the deadline job sequencer.
// ----------------------------------------------------------------------------
`default_nettype none
package djs_pkg;
	localparam int DEADLINE_W = 8;
	localparam int PROFIT_W   = 16;
	localparam int COUNT_W    = 7;
	localparam int SUM_W      = 22;
	localparam logic [COUNT_W-1:0] COUNT_SAT = '1;
	localparam logic [SUM_W-1:0]   SUM_SAT   = '1;

	// one queued job from the front end to the scheduler
	typedef struct packed {
		logic [DEADLINE_W-1:0] deadline;
		logic [PROFIT_W-1:0]   profit;
		logic                  store;  // write into the job store
		logic                  last;   // closes the set
	} job_entry_t;
endpackage
`default_nettype wire

[rtl/core/djs_fifo.sv]
// ----------------------------------------------------------------------------
// djs_fifo
// Short queue between the load front end and the scheduler.
// ----------------------------------------------------------------------------
`default_nettype none
module djs_fifo
	import djs_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       wr_valid,
	output logic            wr_ready,
	input  wire job_entry_t wr_data,
	output logic            rd_valid,
	input  wire logic       rd_ready,
	output job_entry_t      rd_data
);
	job_entry_t mem_q [4];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;
	logic       wr_en, rd_en;

	assign wr_ready = (cnt_q != 3'd4);
	assign rd_valid = (cnt_q != 3'd0);
	assign rd_data  = mem_q[rp_q];
	assign wr_en    = wr_valid && wr_ready;
	assign rd_en    = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wp_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) wp_q <= wp_q + 2'd1;
			if (rd_en) rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + {2'd0, wr_en} - {2'd0, rd_en};
		end
	end
endmodule
`default_nettype wire

[rtl/core/djs_front.sv]
// ----------------------------------------------------------------------------
// djs_front
// Accepts jobs, counts the set and marks entries beyond the store size.
// ----------------------------------------------------------------------------
`default_nettype none
module djs_front
	import djs_pkg::*;
#(
	parameter int MAX_JOBS = 64
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [DEADLINE_W-1:0] job_deadline,
	input  wire logic [PROFIT_W-1:0]   job_profit,
	input  wire logic                  last_job,
	output logic                       q_valid,
	input  wire logic                  q_ready,
	output job_entry_t                 q_data
);
	localparam int CW = $clog2(MAX_JOBS + 1);
	logic [CW-1:0] cnt_q;

	assign q_valid          = in_valid;
	assign in_ready         = q_ready;
	assign q_data.deadline  = job_deadline;
	assign q_data.profit    = job_profit;
	assign q_data.store     = (cnt_q < CW'(MAX_JOBS));
	assign q_data.last      = last_job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (in_valid && q_ready) begin
			if (last_job) cnt_q <= '0;
			else if (cnt_q < CW'(MAX_JOBS)) cnt_q <= cnt_q + CW'(1);
		end
	end
endmodule
`default_nettype wire

[rtl/core/djs_back.sv]
// ----------------------------------------------------------------------------
// djs_back
// Stores the set, then picks jobs by falling profit and assigns slots.
// ----------------------------------------------------------------------------
`default_nettype none
module djs_back
	import djs_pkg::*;
#(
	parameter int MAX_JOBS = 64
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               q_valid,
	output logic                    q_ready,
	input  wire job_entry_t         q_data,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [COUNT_W-1:0]      jobs_scheduled,
	output logic [SUM_W-1:0]        total_profit
);
	localparam int AW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
	localparam int CW = $clog2(MAX_JOBS + 1);

	localparam logic [2:0] ST_LOAD = 3'd0;
	localparam logic [2:0] ST_CLR  = 3'd1;
	localparam logic [2:0] ST_PICK = 3'd2;
	localparam logic [2:0] ST_SRCH = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [2:0] state_q;

	logic [DEADLINE_W-1:0] dl_mem [MAX_JOBS];
	logic [PROFIT_W-1:0]   pr_mem [MAX_JOBS];
	logic [MAX_JOBS-1:0]   used_q;   // job already picked this set
	logic [MAX_JOBS:0]     slot_q;   // slot occupancy, one flip-flop each

	logic [CW-1:0] n_q;        // jobs in the set
	logic [CW-1:0] pick_q;     // picks done
	logic [CW-1:0] scan_q;     // scan index over jobs
	logic [AW-1:0] best_q;
	logic [PROFIT_W-1:0] best_p_q;
	logic          best_v_q;
	logic [CW-1:0] s_q;        // slot search pointer
	logic [COUNT_W-1:0] done_q;
	logic [SUM_W-1:0]   sum_q;
	logic [DEADLINE_W-1:0] rd_dl_q;
	logic [PROFIT_W-1:0]   rd_pr_q;
	logic [AW-1:0]  scan_a;

	assign scan_a = scan_q[AW-1:0];

	assign q_ready        = (state_q == ST_LOAD);
	assign out_valid      = (state_q == ST_DONE);
	assign jobs_scheduled = done_q;
	assign total_profit   = sum_q;

	// store writes and registered reads; the deadline of the winner is ready
	// once the scan has settled, on the first search cycle
	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD && q_valid && q_data.store) begin
			dl_mem[n_q[AW-1:0]] <= q_data.deadline;
			pr_mem[n_q[AW-1:0]] <= q_data.profit;
		end
		rd_dl_q <= dl_mem[best_q];
		rd_pr_q <= pr_mem[scan_a];
	end

	// the scan reads one job per cycle; pr data for index scan_q-1 arrives late
	logic [CW-1:0] prev_q;
	logic          prev_v_q;
	logic [CW-1:0] clamp;
	logic [CW+DEADLINE_W-1:0] dl_ext;
	logic [CW+DEADLINE_W-1:0] n_ext;

	always_comb begin
		dl_ext = (CW+DEADLINE_W)'(rd_dl_q);
		n_ext  = (CW+DEADLINE_W)'(n_q);
		clamp  = (dl_ext > n_ext) ? n_q : CW'(dl_ext);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_LOAD;
			n_q      <= '0;
			pick_q   <= '0;
			scan_q   <= '0;
			best_q   <= '0;
			best_p_q <= '0;
			best_v_q <= 1'b0;
			s_q      <= '0;
			done_q   <= '0;
			sum_q    <= '0;
			used_q   <= '0;
			slot_q   <= '0;
			prev_q   <= '0;
			prev_v_q <= 1'b0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (q_valid) begin
						if (q_data.store) n_q <= n_q + CW'(1);
						if (q_data.last) state_q <= ST_CLR;
					end
				end
				ST_CLR: begin
					used_q   <= '0;
					slot_q   <= '0;
					done_q   <= '0;
					sum_q    <= '0;
					pick_q   <= '0;
					scan_q   <= '0;
					best_v_q <= 1'b0;
					prev_v_q <= 1'b0;
					state_q  <= (n_q == '0) ? ST_DONE : ST_PICK;
				end
				ST_PICK: begin
					// compare the entry read last cycle; strict > keeps arrival order
					if (prev_v_q && !used_q[prev_q[AW-1:0]] &&
					    (!best_v_q || rd_pr_q > best_p_q)) begin
						best_q   <= prev_q[AW-1:0];
						best_p_q <= rd_pr_q;
						best_v_q <= 1'b1;
					end
					if (scan_q < n_q) begin
						prev_q   <= scan_q;
						prev_v_q <= 1'b1;
						scan_q   <= scan_q + CW'(1);
					end else if (prev_v_q) begin
						prev_v_q <= 1'b0;
					end else begin
						state_q <= ST_SRCH;
						s_q     <= '0;
					end
				end
				ST_SRCH: begin
					// first cycle loads the clamped deadline, then walk down
					if (s_q == '0 && best_v_q) begin
						used_q[best_q] <= 1'b1;
						best_v_q <= 1'b0;
						s_q      <= clamp;
						if (clamp == '0) begin
							pick_q <= pick_q + CW'(1);
						end
					end else if (s_q == '0) begin
						if (pick_q == n_q) begin
							state_q <= ST_DONE;
						end else begin
							scan_q   <= '0;
							prev_v_q <= 1'b0;
							state_q  <= ST_PICK;
						end
					end else if (!slot_q[s_q]) begin
						slot_q[s_q] <= 1'b1;
						if (done_q != COUNT_SAT) done_q <= done_q + COUNT_W'(1);
						if ({1'b0, sum_q} + (SUM_W+1)'(best_p_q) > (SUM_W+1)'(SUM_SAT))
							sum_q <= SUM_SAT;
						else
							sum_q <= sum_q + SUM_W'(best_p_q);
						s_q    <= '0;
						pick_q <= pick_q + CW'(1);
					end else begin
						s_q <= s_q - CW'(1);
						if (s_q == CW'(1)) pick_q <= pick_q + CW'(1);
					end
				end
				ST_DONE: begin
					if (out_ready) begin
						n_q     <= '0;
						state_q <= ST_LOAD;
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end
endmodule
`default_nettype wire

[rtl/core/deadline_job_sequencer.sv]
// Loading: one job per cycle while the scheduler waits for a set. Each job of a set of N
// is picked by a scan over all N jobs, then placed by a walk down at most N slots.
// Loads stall while a set is being scheduled.
// Reset: arst_n clears the set count, queue and all control state.
// ----------------------------------------------------------------------------
// deadline_job_sequencer
// Greedy job sequencing with deadlines over a loaded job set.
// ----------------------------------------------------------------------------
`default_nettype none
`include "deadline_job_sequencer_macros.svh"
module deadline_job_sequencer
	import djs_pkg::*;
#(
	parameter int MAX_JOBS = 64
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [DEADLINE_W-1:0] job_deadline,
	input  wire logic [PROFIT_W-1:0]   job_profit,
	input  wire logic                  last_job,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [COUNT_W-1:0]         jobs_scheduled,
	output logic [SUM_W-1:0]           total_profit
);
	logic       fq_valid, fq_ready, bq_valid, bq_ready;
	job_entry_t fq_data, bq_data;

	djs_front #(.MAX_JOBS(MAX_JOBS)) u_front (
		.clk, .arst_n, .in_valid, .in_ready, .job_deadline, .job_profit, .last_job,
		.q_valid(fq_valid), .q_ready(fq_ready), .q_data(fq_data)
	);

	djs_fifo u_fifo (
		.clk, .arst_n,
		.wr_valid(fq_valid), .wr_ready(fq_ready), .wr_data(fq_data),
		.rd_valid(bq_valid), .rd_ready(bq_ready), .rd_data(bq_data)
	);

	djs_back #(.MAX_JOBS(MAX_JOBS)) u_back (
		.clk, .arst_n, .q_valid(bq_valid), .q_ready(bq_ready), .q_data(bq_data),
		.out_valid, .out_ready, .jobs_scheduled, .total_profit
	);

	`DJS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(total_profit))
	`DJS_ASSERT_IMPL(a_no_load_busy, out_valid, !bq_ready)
	`DJS_ASSERT_IMPL(a_cnt_le_jobs, out_valid, int'(jobs_scheduled) <= MAX_JOBS)
endmodule
`default_nettype wire

[test/tb_deadline_job_sequencer.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_deadline_job_sequencer
// Loads directed job sets and sets of random size and content, predicts the greedy schedule
// (count and profit sum) per set and checks each result against it.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_deadline_job_sequencer;
	import djs_pkg::*;

	localparam int MAX_JOBS = 64;
	localparam int IDLE_LIMIT = 400000;

	typedef struct {
		logic [DEADLINE_W-1:0] deadline;
		logic [PROFIT_W-1:0]   profit;
		logic                  last;
	} job_t;

	typedef struct {
		logic [COUNT_W-1:0] count;
		logic [SUM_W-1:0]   sum;
	} schedule_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [DEADLINE_W-1:0] job_deadline = '0;
	logic [PROFIT_W-1:0] job_profit = '0;
	logic last_job = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [COUNT_W-1:0] jobs_scheduled;
	logic [SUM_W-1:0] total_profit;

	job_t pending_jobs[$];
	schedule_t expected_schedules[$];
	logic [DEADLINE_W-1:0] held_deadlines[MAX_JOBS];
	logic [PROFIT_W-1:0] held_profits[MAX_JOBS];
	int held_count = 0;
	int error_count = 0;
	int sets_checked = 0;
	int jobs_sent = 0;
	int idle_cycles = 0;
	int send_gap = 0;
	int recv_gap = 0;
	bit stimulus_done = 0;

	deadline_job_sequencer #(.MAX_JOBS(MAX_JOBS)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.job_deadline(job_deadline), .job_profit(job_profit), .last_job(last_job),
		.out_valid(out_valid), .out_ready(out_ready),
		.jobs_scheduled(jobs_scheduled), .total_profit(total_profit)
	);

	always #10 clk = ~clk;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 80);
	endfunction

	// greedy schedule over the held jobs, profit descending, latest free slot
	function automatic schedule_t schedule_set(int n);
		schedule_t res;
		bit taken[MAX_JOBS+1];
		bit used[MAX_JOBS];
		int best, s, done;
		longint sum;
		done = 0;
		sum = 0;
		foreach (taken[k]) taken[k] = 0;
		foreach (used[k]) used[k] = 0;
		for (int i = 0; i < n; i++) begin
			best = -1;
			for (int j = 0; j < n; j++)
				if (!used[j] && (best < 0 || held_profits[j] > held_profits[best]))
					best = j;
			used[best] = 1;
			s = held_deadlines[best];
			if (s > n) s = n;
			while (s > 0 && taken[s]) s--;
			if (s > 0) begin
				taken[s] = 1;
				done++;
				sum += held_profits[best];
			end
		end
		res.count = (done > 127) ? COUNT_SAT : COUNT_W'(done);
		res.sum = (sum > 4194303) ? SUM_SAT : SUM_W'(sum);
		return res;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("ERROR %0t: %s", $realtime, msg);
		error_count++;
	endtask

	function automatic void add_job(int d, int p, bit last);
		job_t j;
		j.deadline = DEADLINE_W'(d);
		j.profit = PROFIT_W'(p);
		j.last = last;
		pending_jobs.insert(pending_jobs.size(), j);
	endfunction

	function automatic void add_random_set(int n);
		int mode, d;
		mode = $urandom_range(0, 3);
		for (int i = 0; i < n; i++) begin
			case (mode)
				0: d = $urandom_range(0, 255);
				1: d = $urandom_range(0, n + 1);
				default: d = $urandom_range(1, (n > 8) ? n / 2 : n);
			endcase
			add_job(d, (mode == 3) ? $urandom_range(0, 7) * 9000 : $urandom_range(0, 65535),
				i == n - 1);
		end
	endfunction

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				jobs_sent++;
				if (held_count < MAX_JOBS) begin
					held_deadlines[held_count] = job_deadline;
					held_profits[held_count] = job_profit;
					held_count++;
				end
				if (last_job) begin
					expected_schedules.insert(expected_schedules.size(),
						schedule_set(held_count));
					held_count = 0;
				end
				send_gap = pick_gap();
			end
			if (!in_valid || in_ready) begin
				if (send_gap == 0 && pending_jobs.size() > 0) begin
					in_valid <= 1'b1;
					job_deadline <= pending_jobs[0].deadline;
					job_profit <= pending_jobs[0].profit;
					last_job <= pending_jobs[0].last;
					void'(pending_jobs.pop_front());
				end else begin
					in_valid <= 1'b0;
					if (send_gap > 0) send_gap--;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_schedules.size() == 0)
					report_mismatch("result with no set pending");
				else begin
					if (jobs_scheduled !== expected_schedules[0].count)
						report_mismatch($sformatf("jobs_scheduled %0d, expected %0d",
							jobs_scheduled, expected_schedules[0].count));
					if (total_profit !== expected_schedules[0].sum)
						report_mismatch($sformatf("total_profit %0d, expected %0d",
							total_profit, expected_schedules[0].sum));
					void'(expected_schedules.pop_front());
				end
				sets_checked++;
			end
			if (recv_gap > 0) begin
				recv_gap--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if ($urandom_range(0, 3) == 0) recv_gap = pick_gap();
			end
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout with %0d results outstanding", expected_schedules.size());
			$display("tb_deadline_job_sequencer failed");
			$finish;
		end
	end

	initial begin
		int n;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// directed: single jobs, zero deadline, extremes, clamping, overflow of store
		add_job(0, 65535, 1);
		add_job(255, 65535, 1);
		add_job(1, 0, 1);
		add_job(1, 100, 0); add_job(1, 200, 0); add_job(1, 200, 1);
		add_job(255, 65535, 0); add_job(255, 65535, 0); add_job(0, 5, 0);
		add_job(2, 7, 1);
		add_job(3, 10, 0); add_job(1, 20, 0); add_job(2, 30, 0); add_job(3, 40, 1);
		for (int i = 0; i < MAX_JOBS; i++) add_job(255, 65535, 0);
		add_job(1, 1, 0); add_job(170, 21845, 1);
		for (int i = 0; i < MAX_JOBS - 1; i++) add_job(85, 43690, 0);
		add_job(64, 1234, 1);

		while (pending_jobs.size() + jobs_sent < 1900) begin
			case ($urandom_range(0, 9))
				0: n = $urandom_range(30, MAX_JOBS);
				1: n = $urandom_range(MAX_JOBS + 1, MAX_JOBS + 4);
				default: n = $urandom_range(1, 12);
			endcase
			add_random_set(n);
		end

		wait (pending_jobs.size() == 0 && !in_valid);
		wait (expected_schedules.size() == 0);
		repeat (50) @(posedge clk);
		$display("sent %0d jobs, checked %0d scheduled sets", jobs_sent, sets_checked);
		$display("sets ranged from single jobs to full and overfull stores");
		if (error_count == 0 && expected_schedules.size() == 0)
			$display("tb_deadline_job_sequencer passed");
		else
			$display("tb_deadline_job_sequencer failed");
		$finish;
	end
endmodule
`default_nettype wire
